/* hdl/pslt_pkg.sv */
// Shared types and constants for the PAL sync line tracker.
// Used by every module of the block; depends on nothing.
package pslt_pkg;

  localparam int TIME_W  = 64;
  localparam int CLK_W   = 27;
  localparam int CYC_W   = 12;
  localparam int CNT_W   = 16;
  localparam int LINE_W  = 10;
  localparam int PIX_W   = 10;
  localparam int PROD_W  = TIME_W + CLK_W;
  localparam int MDCNT_W = 7;
  localparam int QDEPTH  = 2;

  localparam logic [CLK_W-1:0]  US_SCALE   = 27'd4000000;
  localparam logic [CLK_W-1:0]  CLK_RESET  = 27'd20000000;
  localparam logic [CYC_W-1:0]  C64_RESET  = 12'd320;
  localparam logic [CYC_W-1:0]  C70_RESET  = 12'd350;
  localparam logic [TIME_W-1:0] LINE_US    = 64'd64;
  localparam logic [TIME_W-1:0] SKIP_US    = 64'd70;
  localparam logic [TIME_W-1:0] SYNC_LO_US = 64'd25;
  localparam logic [TIME_W-1:0] SYNC_HI_US = 64'd35;
  localparam logic [LINE_W-1:0] FIELD1_LINE = 10'd6;
  localparam logic [LINE_W-1:0] FIELD2_LINE = 10'd318;

  typedef struct packed {
    logic [TIME_W-1:0] cycle_time;
    logic              luma;
    logic              fall;
    logic              rise;
  } ev_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] a;
    logic [CLK_W-1:0]  m;
    logic [CLK_W-1:0]  b;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] q;
  } md_rsp_t;

  typedef struct packed {
    logic              line_skipped;
    logic              vsync_error;
    logic              second_field;
    logic              frame_start;
    logic [LINE_W-1:0] finished_line;
    logic              line_done;
    logic              pixel_white;
    logic [PIX_W-1:0]  pixel_index;
    logic [LINE_W-1:0] line_number;
  } res_t;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_state_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_CA_GO, BK_CA_WAIT, BK_CB_GO, BK_CB_WAIT,
    BK_IDX_GO, BK_IDX_WAIT, BK_RISE_GO, BK_RISE_WAIT, BK_OUT
  } bk_state_t;

endpackage

/* hdl/pslt_front.sv */
// Front end: accepts pin-change items and classifies the sync edge.
// Depends on pslt_pkg; feeds the event queue.
module pslt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [71:0]          s_axis_tdata,  // cycle_time, sync_level, luma_level, zero pad
  input  logic                 q_full,
  output logic                 q_push,
  output pslt_pkg::ev_t        q_data
);

  logic prev_sync;
  logic sync_in;

  assign sync_in       = s_axis_tdata[64];
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  assign q_data.cycle_time = s_axis_tdata[63:0];
  assign q_data.luma       = s_axis_tdata[65];
  assign q_data.fall       = prev_sync && !sync_in;
  assign q_data.rise       = !prev_sync && sync_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sync <= 1'b0;
    end else if (q_push) begin
      prev_sync <= sync_in;
    end
  end

endmodule

/* hdl/pslt_queue.sv */
// Short event queue between the front end and the back end.
// Depends on pslt_pkg for the entry type and depth.
module pslt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pslt_pkg::ev_t wdata,
  input  logic          pop,
  output pslt_pkg::ev_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int PW = $clog2(pslt_pkg::QDEPTH);

  pslt_pkg::ev_t mem [pslt_pkg::QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;

  assign full  = count == (PW+1)'(pslt_pkg::QDEPTH);
  assign empty = count == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(pslt_pkg::QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

/* hdl/pslt_muldiv.sv */
// Shared serial unit computing floor(a * m / b), saturated to 64 bits, 0 when b is 0.
// Shift-add multiply, then restoring division one bit a cycle.
module pslt_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  pslt_pkg::md_req_t req,
  output pslt_pkg::md_rsp_t rsp
);

  localparam int PW = pslt_pkg::PROD_W;
  localparam int MW = pslt_pkg::CLK_W;
  localparam int QW = pslt_pkg::TIME_W;

  pslt_pkg::md_state_t state, state_next;
  logic [PW-1:0]               acc, a_sh;
  logic [MW-1:0]               m_sh, dvs;
  logic [MW-1:0]               rem;
  logic [QW-1:0]               quo;
  logic                        ovf;
  logic [pslt_pkg::MDCNT_W-1:0] cnt;
  logic [MW:0]                 rem_t;
  logic                        fits;

  assign rem_t = {rem, acc[PW-1]};
  assign fits  = rem_t >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pslt_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rsp.done   = 1'b0;
    rsp.q      = (dvs == '0) ? '0 : (ovf ? '1 : quo);
    unique case (state)
      pslt_pkg::MD_IDLE: if (req.start) state_next = pslt_pkg::MD_MUL;
      pslt_pkg::MD_MUL:  if (cnt == '0) state_next = pslt_pkg::MD_DIV;
      pslt_pkg::MD_DIV:  if (cnt == '0) state_next = pslt_pkg::MD_DONE;
      pslt_pkg::MD_DONE: begin
        rsp.done   = 1'b1;
        state_next = pslt_pkg::MD_IDLE;
      end
      default: state_next = pslt_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      pslt_pkg::MD_IDLE: begin
        acc  <= '0;
        a_sh <= {{(PW-QW){1'b0}}, req.a};
        m_sh <= req.m;
        dvs  <= req.b;
        cnt  <= pslt_pkg::MDCNT_W'(MW - 1);
      end
      pslt_pkg::MD_MUL: begin
        if (m_sh[0]) acc <= acc + a_sh;
        a_sh <= a_sh << 1;
        m_sh <= m_sh >> 1;
        if (cnt == '0) begin
          cnt <= pslt_pkg::MDCNT_W'(PW - 1);
          rem <= '0;
          quo <= '0;
          ovf <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      pslt_pkg::MD_DIV: begin
        acc <= acc << 1;
        rem <= fits ? MW'(rem_t - {1'b0, dvs}) : rem_t[MW-1:0];
        quo <= {quo[QW-2:0], fits};
        ovf <= ovf | quo[QW-1];
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) rsp.done |=> !rsp.done)
    else $error("divider done held longer than one cycle");
  a_start_no_done: assert property (@(posedge clk) disable iff (rst)
    (req.start && state == pslt_pkg::MD_IDLE) |=> !rsp.done)
    else $error("divider finished right after start");
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (rsp.done && dvs == '0) |-> rsp.q == '0)
    else $error("zero divisor gave nonzero result");
`endif

endmodule

/* hdl/pslt_back.sv */
// Back end: line tracking state, time conversions through the shared divider, result register.
// Depends on pslt_pkg; takes items from the event queue and drives the master stream.
module pslt_back #(
  parameter int LINE_WIDTH = 640,
  parameter int LINE_COUNT = 625
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pslt_pkg::CLK_W-1:0]    cfg_data,
  input  logic                          q_empty,
  input  pslt_pkg::ev_t                 q_data,
  output logic                          q_pop,
  output pslt_pkg::md_req_t             md_req,
  input  pslt_pkg::md_rsp_t             md_rsp,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata
);

  localparam int TW      = pslt_pkg::TIME_W;
  localparam int FACTOR  = LINE_WIDTH / 64;
  localparam int FW      = $clog2(FACTOR + 1);
  localparam int LW_HI   = LINE_WIDTH - LINE_WIDTH / 5;
  localparam int LW_LO3  = LINE_WIDTH / 3;
  localparam int LW_HI3  = LINE_WIDTH - LINE_WIDTH / 3;

  pslt_pkg::bk_state_t state, state_next;
  logic [pslt_pkg::CLK_W-1:0]  clk_hz;
  logic [pslt_pkg::CYC_W-1:0]  c64, c70;
  logic [TW-1:0]               set_t;
  logic [pslt_pkg::CNT_W-1:0]  short_cnt, prev_short;
  logic [pslt_pkg::LINE_W-1:0] line;
  pslt_pkg::ev_t               ev;
  logic                        skip;
  pslt_pkg::res_t              res;

  logic [TW-1:0]      delta, scaled, c64_ext;
  logic [TW+FW-1:0]   prod;
  logic               out_free;

  // Outcome of the sync edge once the pixel position is known.
  logic [TW-1:0]               set_n, idx_c;
  logic [pslt_pkg::LINE_W-1:0] line_n, fin;
  logic [pslt_pkg::LINE_W:0]   line_inc;
  logic [pslt_pkg::CNT_W-1:0]  sc_n, psc_n;
  logic                        ld, fs, f2, ve;
  logic [pslt_pkg::PIX_W-1:0]  pix;

  assign c64_ext  = TW'(c64);
  assign delta    = ev.cycle_time - set_t;
  assign prod     = {{FW{1'b0}}, delta} * (TW+FW)'(FACTOR);
  assign scaled   = (prod[TW+FW-1:TW] != '0) ? '1 : prod[TW-1:0];
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = state == pslt_pkg::BK_IDLE;

  always_comb begin
    set_n    = skip ? set_t + c64_ext : set_t;
    line_n   = line;
    sc_n     = short_cnt;
    psc_n    = prev_short;
    ld       = 1'b0;
    fin      = '0;
    fs       = 1'b0;
    f2       = 1'b0;
    ve       = 1'b0;
    idx_c    = md_rsp.q;
    line_inc = '0;
    if (ev.fall) begin
      set_n = ev.cycle_time;
      if (md_rsp.q > TW'(LW_HI)) begin
        if (short_cnt != '0) begin
          if (short_cnt > prev_short) begin
            line_n = pslt_pkg::FIELD1_LINE;
            fs     = 1'b1;
          end else if (short_cnt < prev_short) begin
            line_n = pslt_pkg::FIELD2_LINE;
            f2     = 1'b1;
          end else begin
            ve = 1'b1;
          end
          psc_n = short_cnt;
          sc_n  = '0;
        end
        ld       = 1'b1;
        fin      = line_n;
        line_inc = {1'b0, line_n} + 1'b1;
        line_n   = (line_inc >= (pslt_pkg::LINE_W+1)'(LINE_COUNT)) ? '0
                 : line_inc[pslt_pkg::LINE_W-1:0];
        idx_c    = '0;
      end else if (md_rsp.q > TW'(LW_LO3) && md_rsp.q < TW'(LW_HI3)) begin
        if (short_cnt != '1) sc_n = short_cnt + 1'b1;
      end
    end
    pix = (idx_c >= TW'(LINE_WIDTH)) ? pslt_pkg::PIX_W'(LINE_WIDTH - 1)
        : idx_c[pslt_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pslt_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    md_req.start = 1'b0;
    md_req.a     = scaled;
    md_req.m     = pslt_pkg::US_SCALE;
    md_req.b     = clk_hz;
    unique case (state)
      pslt_pkg::BK_IDLE: begin
        if (cfg_valid) begin
          state_next = pslt_pkg::BK_CA_GO;
        end else if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = pslt_pkg::BK_IDX_GO;
        end
      end
      pslt_pkg::BK_CA_GO: begin
        md_req.start = 1'b1;
        md_req.a     = pslt_pkg::LINE_US;
        md_req.m     = clk_hz;
        md_req.b     = pslt_pkg::US_SCALE;
        state_next   = pslt_pkg::BK_CA_WAIT;
      end
      pslt_pkg::BK_CA_WAIT: if (md_rsp.done) state_next = pslt_pkg::BK_CB_GO;
      pslt_pkg::BK_CB_GO: begin
        md_req.start = 1'b1;
        md_req.a     = pslt_pkg::SKIP_US;
        md_req.m     = clk_hz;
        md_req.b     = pslt_pkg::US_SCALE;
        state_next   = pslt_pkg::BK_CB_WAIT;
      end
      pslt_pkg::BK_CB_WAIT: if (md_rsp.done) state_next = pslt_pkg::BK_IDLE;
      pslt_pkg::BK_IDX_GO: begin
        md_req.start = 1'b1;
        state_next   = pslt_pkg::BK_IDX_WAIT;
      end
      pslt_pkg::BK_IDX_WAIT: begin
        if (md_rsp.done) state_next = ev.rise ? pslt_pkg::BK_RISE_GO : pslt_pkg::BK_OUT;
      end
      pslt_pkg::BK_RISE_GO: begin
        md_req.start = 1'b1;
        md_req.a     = delta;
        state_next   = pslt_pkg::BK_RISE_WAIT;
      end
      pslt_pkg::BK_RISE_WAIT: if (md_rsp.done) state_next = pslt_pkg::BK_OUT;
      pslt_pkg::BK_OUT: if (out_free) state_next = pslt_pkg::BK_IDLE;
      default: state_next = pslt_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz     <= pslt_pkg::CLK_RESET;
      c64        <= pslt_pkg::C64_RESET;
      c70        <= pslt_pkg::C70_RESET;
      set_t      <= '0;
      short_cnt  <= '0;
      prev_short <= '0;
      line       <= '0;
    end else begin
      case (state)
        pslt_pkg::BK_IDLE: begin
          if (cfg_valid) begin
            clk_hz <= cfg_data;
          end else if (!q_empty) begin
            ev <= q_data;
            if (set_t > q_data.cycle_time) set_t <= set_t + c64_ext;
          end
        end
        pslt_pkg::BK_CA_WAIT: if (md_rsp.done) c64 <= md_rsp.q[pslt_pkg::CYC_W-1:0];
        pslt_pkg::BK_CB_WAIT: if (md_rsp.done) c70 <= md_rsp.q[pslt_pkg::CYC_W-1:0];
        pslt_pkg::BK_IDX_GO: skip <= delta > TW'(c70);
        pslt_pkg::BK_IDX_WAIT: begin
          if (md_rsp.done) begin
            set_t      <= set_n;
            line       <= line_n;
            short_cnt  <= sc_n;
            prev_short <= psc_n;
            res.line_number   <= line_n;
            res.pixel_index   <= pix;
            res.pixel_white   <= ev.luma;
            res.line_done     <= ld;
            res.finished_line <= fin;
            res.frame_start   <= fs;
            res.second_field  <= f2;
            res.vsync_error   <= ve;
            res.line_skipped  <= skip;
          end
        end
        pslt_pkg::BK_RISE_WAIT: begin
          if (md_rsp.done && md_rsp.q > pslt_pkg::SYNC_LO_US
              && md_rsp.q < pslt_pkg::SYNC_HI_US) begin
            short_cnt <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == pslt_pkg::BK_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pslt_pkg::BK_OUT && out_free) begin
      m_axis_tdata <= {4'b0, res};
    end
  end

`ifndef SYNTHESIS
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    line < pslt_pkg::LINE_W'(LINE_COUNT))
    else $error("line counter out of range");
  a_field_flags: assert property (@(posedge clk) disable iff (rst)
    state == pslt_pkg::BK_OUT |-> $onehot0({res.frame_start, res.second_field, res.vsync_error}))
    else $error("more than one field flag set");
  a_pix_range: assert property (@(posedge clk) disable iff (rst)
    state == pslt_pkg::BK_OUT |->
      {1'b0, res.pixel_index} < (pslt_pkg::PIX_W+1)'(LINE_WIDTH))
    else $error("pixel index beyond line width");
  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    (state == pslt_pkg::BK_OUT && !res.line_done) |-> res.finished_line == '0)
    else $error("finished line set without line end");
`endif

endmodule

/* hdl/pal_sync_line_tracker_unit.sv */
// PAL sync line tracker: one item per pin change, one result item per input item.
// Each item takes one pass of the serial multiply-divide unit; a rising sync edge,
// which needs a second pass, takes two; items are done one at a time.
// A clock_hz write costs two passes before the next item starts.
// Synchronous active-high reset: clock_hz 20 MHz, all tracking state zero, queue empty.
module pal_sync_line_tracker_unit #(
  parameter int LINE_WIDTH = 640,
  parameter int LINE_COUNT = 625
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // cycle_time[63:0], sync_level[64], luma_level[65], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // line_number[9:0], pixel_index[19:10], pixel_white[20], line_done[21],
  // finished_line[31:22], frame_start[32], second_field[33], vsync_error[34],
  // line_skipped[35], zero
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [26:0] cfg_data
);

  pslt_pkg::ev_t     push_data, pop_data;
  logic              q_push, q_pop, q_full, q_empty;
  pslt_pkg::md_req_t md_req;
  pslt_pkg::md_rsp_t md_rsp;

  pslt_front u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .q_full(q_full), .q_push(q_push), .q_data(push_data)
  );

  pslt_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata(push_data), .pop(q_pop), .rdata(pop_data),
    .full(q_full), .empty(q_empty)
  );

  pslt_muldiv u_muldiv (
    .clk(clk), .rst(rst), .req(md_req), .rsp(md_rsp)
  );

  pslt_back #(.LINE_WIDTH(LINE_WIDTH), .LINE_COUNT(LINE_COUNT)) u_back (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .q_empty(q_empty), .q_data(pop_data), .q_pop(q_pop),
    .md_req(md_req), .md_rsp(md_rsp),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

endmodule
